FILE: design/wav_stream_deframer_defines.svh
// Assertion macros shared by the deframer RTL.
`ifndef WAV_STREAM_DEFRAMER_DEFINES_SVH
`define WAV_STREAM_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define WSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/wsd_pkg.sv
package wsd_pkg;

  // Input beat: one file byte or the finish command.
  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } item_t;

  // Result beat, one per input beat.
  typedef struct packed {
    logic       pcm_valid;
    logic [7:0] pcm_byte;
    logic       status;
    logic       format_known;
    logic       rate_is_high;
  } result_t;

  // Command codes.
  localparam logic CMD_BYTE   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Chunk ids, first byte of the id in the low byte.
  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;
  localparam logic [31:0] ID_FMT  = 32'h2074_6d66;

  localparam logic [31:0] MIN_RIFF_SIZE = 32'd4;
  localparam logic [31:0] FMT_SIZE      = 32'd16;
  localparam logic [2:0]  FORM_TYPE_LEN = 3'd4;

  localparam logic [3:0]  HDR_LAST      = 4'd7;
  localparam logic [4:0]  FMT_LAST      = 5'd15;

  // fmt chunk field values that are accepted.
  localparam logic [15:0] FMT_TAG_PCM   = 16'd1;
  localparam logic [15:0] FMT_CHANNELS  = 16'd1;
  localparam logic [15:0] FMT_BITS      = 16'd16;
  localparam logic [15:0] FMT_ALIGN     = 16'd2;
  localparam logic [31:0] RATE_LOW      = 32'd16000;
  localparam logic [31:0] RATE_HIGH     = 32'd24000;
  localparam logic [31:0] BYTE_RATE_LOW  = 32'd32000;
  localparam logic [31:0] BYTE_RATE_HIGH = 32'd48000;

endpackage

FILE: design/wsd_parser.sv
`include "wav_stream_deframer_defines.svh"

// Parse state and the per-byte update; result is combinational from the
// current beat and the updated state.
module wsd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  wsd_pkg::item_t   item,
  output wsd_pkg::result_t result
);

  logic [7:0]  header_store [8];
  logic [7:0]  fmt_store [16];

  logic [3:0]  header_count, header_count_next;
  logic [31:0] chunk_left, chunk_left_next;
  logic [2:0]  form_tail_left, form_tail_left_next;
  logic        pad_pending, pad_pending_next;
  logic        pad_after_skip, pad_after_skip_next;
  logic        in_payload, in_payload_next;
  logic        riff_ok, riff_ok_next;
  logic        fmt_ok, fmt_ok_next;
  logic        payload_seen, payload_seen_next;
  logic        in_fmt, in_fmt_next;
  logic [4:0]  fmt_count, fmt_count_next;
  logic        high_rate, high_rate_next;
  logic        error_flag, error_flag_next;

  logic        hdr_we, fmt_we, pcm_valid;
  logic [31:0] hdr_id, hdr_size;
  logic [15:0] f_tag, f_chan, f_align, f_bits;
  logic [31:0] f_rate, f_brate;
  logic        fmt_good;

  // The last header or fmt byte is the current beat, not yet stored.
  assign hdr_id   = {header_store[3], header_store[2], header_store[1], header_store[0]};
  assign hdr_size = {item.data_byte, header_store[6], header_store[5], header_store[4]};
  assign f_tag    = {fmt_store[1], fmt_store[0]};
  assign f_chan   = {fmt_store[3], fmt_store[2]};
  assign f_rate   = {fmt_store[7], fmt_store[6], fmt_store[5], fmt_store[4]};
  assign f_brate  = {fmt_store[11], fmt_store[10], fmt_store[9], fmt_store[8]};
  assign f_align  = {fmt_store[13], fmt_store[12]};
  assign f_bits   = {item.data_byte, fmt_store[14]};

  assign fmt_good = (f_tag == wsd_pkg::FMT_TAG_PCM) && (f_chan == wsd_pkg::FMT_CHANNELS)
                 && (f_bits == wsd_pkg::FMT_BITS) && (f_align == wsd_pkg::FMT_ALIGN)
                 && (((f_rate == wsd_pkg::RATE_LOW) && (f_brate == wsd_pkg::BYTE_RATE_LOW))
                  || ((f_rate == wsd_pkg::RATE_HIGH) && (f_brate == wsd_pkg::BYTE_RATE_HIGH)));

  always_comb begin
    header_count_next   = header_count;
    chunk_left_next     = chunk_left;
    form_tail_left_next = form_tail_left;
    pad_pending_next    = pad_pending;
    pad_after_skip_next = pad_after_skip;
    in_payload_next     = in_payload;
    riff_ok_next        = riff_ok;
    fmt_ok_next         = fmt_ok;
    payload_seen_next   = payload_seen;
    in_fmt_next         = in_fmt;
    fmt_count_next      = fmt_count;
    high_rate_next      = high_rate;
    error_flag_next     = error_flag;
    hdr_we              = 1'b0;
    fmt_we              = 1'b0;
    pcm_valid           = 1'b0;

    if (accept) begin
      if (item.cmd == wsd_pkg::CMD_FINISH) begin
        if (!riff_ok || !fmt_ok || !payload_seen || in_payload || (chunk_left != '0)
            || (header_count != '0)) begin
          error_flag_next = 1'b1;
        end
      end else if (!error_flag) begin
        if (in_payload) begin
          pcm_valid       = 1'b1;
          chunk_left_next = chunk_left - 32'd1;
          if (chunk_left == 32'd1) begin
            in_payload_next  = 1'b0;
            pad_pending_next = 1'b0;
          end
        end else if (form_tail_left != '0) begin
          form_tail_left_next = form_tail_left - 3'd1;
        end else if (pad_pending) begin
          pad_pending_next = 1'b0;
        end else if (chunk_left != '0) begin
          chunk_left_next = chunk_left - 32'd1;
          if (in_fmt) begin
            fmt_we         = 1'b1;
            fmt_count_next = fmt_count + 5'd1;
            if (fmt_count == wsd_pkg::FMT_LAST) begin
              in_fmt_next = 1'b0;
              if (fmt_good) begin
                fmt_ok_next    = 1'b1;
                high_rate_next = (f_rate == wsd_pkg::RATE_HIGH);
              end else begin
                error_flag_next = 1'b1;
              end
            end
          end else if ((chunk_left == 32'd1) && pad_after_skip) begin
            pad_pending_next    = 1'b1;
            pad_after_skip_next = 1'b0;
          end
        end else begin
          hdr_we            = 1'b1;
          header_count_next = header_count + 4'd1;
          if (header_count == wsd_pkg::HDR_LAST) begin
            header_count_next = '0;
            if (!riff_ok) begin
              if ((hdr_id != wsd_pkg::ID_RIFF) || (hdr_size < wsd_pkg::MIN_RIFF_SIZE)) begin
                error_flag_next = 1'b1;
              end else begin
                riff_ok_next        = 1'b1;
                form_tail_left_next = wsd_pkg::FORM_TYPE_LEN;
              end
            end else if (hdr_id == wsd_pkg::ID_DATA) begin
              if (!fmt_ok || (hdr_size == '0) || hdr_size[0]) begin
                error_flag_next = 1'b1;
              end else begin
                payload_seen_next = 1'b1;
                chunk_left_next   = hdr_size;
                in_payload_next   = 1'b1;
              end
            end else if (hdr_id == wsd_pkg::ID_FMT) begin
              if (hdr_size != wsd_pkg::FMT_SIZE) begin
                error_flag_next = 1'b1;
              end else begin
                chunk_left_next = wsd_pkg::FMT_SIZE;
                in_fmt_next     = !fmt_ok;
                fmt_count_next  = '0;
              end
            end else begin
              chunk_left_next     = hdr_size;
              pad_after_skip_next = hdr_size[0];
            end
          end
        end
      end
    end

    result.pcm_valid    = pcm_valid;
    result.pcm_byte     = pcm_valid ? item.data_byte : 8'd0;
    result.status       = error_flag_next;
    result.format_known = fmt_ok_next;
    result.rate_is_high = high_rate_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count   <= '0;
      chunk_left     <= '0;
      form_tail_left <= '0;
      pad_pending    <= 1'b0;
      pad_after_skip <= 1'b0;
      in_payload     <= 1'b0;
      riff_ok        <= 1'b0;
      fmt_ok         <= 1'b0;
      payload_seen   <= 1'b0;
      in_fmt         <= 1'b0;
      fmt_count      <= '0;
      high_rate      <= 1'b0;
      error_flag     <= 1'b0;
    end else begin
      header_count   <= header_count_next;
      chunk_left     <= chunk_left_next;
      form_tail_left <= form_tail_left_next;
      pad_pending    <= pad_pending_next;
      pad_after_skip <= pad_after_skip_next;
      in_payload     <= in_payload_next;
      riff_ok        <= riff_ok_next;
      fmt_ok         <= fmt_ok_next;
      payload_seen   <= payload_seen_next;
      in_fmt         <= in_fmt_next;
      fmt_count      <= fmt_count_next;
      high_rate      <= high_rate_next;
      error_flag     <= error_flag_next;
    end
  end

  // Byte stores, no reset: read only after fully written.
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      header_store[header_count[2:0]] <= item.data_byte;
    end
    if (fmt_we) begin
      fmt_store[fmt_count[3:0]] <= item.data_byte;
    end
  end

  `WSD_ASSERT_NEXT(a_error_sticky, error_flag, error_flag, "error flag dropped")
  `WSD_ASSERT_NEXT(a_format_sticky, fmt_ok, fmt_ok, "format_known dropped")
  `WSD_ASSERT_NOW(a_payload_len, in_payload, chunk_left != '0, "payload with no bytes left")
  `WSD_ASSERT_NOW(a_pcm_in_payload, accept && result.pcm_valid, in_payload && !error_flag,
                  "pcm byte outside a data chunk")

endmodule

FILE: design/wsd_skid.sv
`include "wav_stream_deframer_defines.svh"

// Two-entry result buffer: output register plus one skid entry.
module wsd_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             beat_valid,
  input  wsd_pkg::result_t beat,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output wsd_pkg::result_t out_beat
);

  logic             skid_valid;
  wsd_pkg::result_t skid_beat;
  logic             take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_beat   <= skid_beat;
        skid_valid <= 1'b0;
      end
    end else if (beat_valid) begin
      if (!out_valid || take) begin
        out_beat  <= beat;
        out_valid <= 1'b1;
      end else begin
        skid_beat  <= beat;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  `WSD_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid entry without output beat")
  `WSD_ASSERT_NOW(a_no_overrun, skid_valid, !beat_valid, "beat offered while buffer full")
  `WSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_beat),
                   "stalled result beat changed")

endmodule

FILE: design/wav_stream_deframer.sv
// WAV stream deframer: takes a RIFF/WAVE file one byte per beat and passes out
// the bytes of each data chunk as PCM bytes, after checking the RIFF header and
// requiring a 16-byte fmt chunk of mono 16-bit PCM at 16000 or 24000 Hz.
// Every input beat (a file byte, or the finish command with cmd = 1) yields
// exactly one result beat carrying pcm_valid/pcm_byte and the running status,
// format_known and rate_is_high flags. Throughput is one beat per clock while
// item_stall is low; each result is formed combinationally by the parser and
// registered in the output register, or in the skid entry while that is stalled.
// A two-entry output buffer lets input keep flowing while a result waits:
// item_stall rises only once two results are held. Errors are sticky until rst.
module wav_stream_deframer (
  input  logic             clk,
  input  logic             rst,
  // byte / command channel
  input  logic             item_valid,
  output logic             item_stall,
  input  wsd_pkg::item_t   item,
  // result channel
  output logic             result_valid,
  input  logic             result_stall,
  output wsd_pkg::result_t result
);

  logic             accept;
  logic             buf_full;
  wsd_pkg::result_t step_result;

  // A beat is taken whenever the skid entry is free.
  assign item_stall = buf_full;
  assign accept     = item_valid && !buf_full;

  // Header, fmt and chunk tracking; result for the beat comes out same cycle.
  wsd_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .result (step_result)
  );

  // Output register plus skid entry decouple the two channels.
  wsd_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (accept),
    .beat       (step_result),
    .full       (buf_full),
    .out_valid  (result_valid),
    .out_stall  (result_stall),
    .out_beat   (result)
  );

endmodule
